// ===== design/fpc_pkg.sv =====
// Package for the frustum plane point cull core: widths, constants and helpers.
// Used by every module of the block; depends on nothing.
package fpc_pkg;
    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NORM_BITS     = 30;
    localparam int ACC_WIDTH     = 52;
    localparam int PROD_WIDTH    = 64;
    localparam int SUM_WIDTH     = 62;
    localparam int LEN_WIDTH     = 31;
    localparam int QUO_WIDTH     = VALUE_WIDTH;
    localparam int DIST_WIDTH    = 68;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic signed [ACC_WIDTH-1:0]   t_acc;

    typedef enum logic [1:0] {
        KIND_LOAD_PROJ = 2'd0,
        KIND_LOAD_VIEW = 2'd1,
        KIND_COMPUTE   = 2'd2,
        KIND_TEST      = 2'd3
    } t_kind;

    localparam logic [2:0] PLANE_NONE = 3'd6;
    localparam int         NUM_PLANES = 6;

    // Column used by each plane and whether it is added to column three.
    function automatic logic [1:0] plane_col(input logic [2:0] p);
        return p[2:1];
    endfunction

    function automatic logic plane_add(input logic [2:0] p);
        return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction
endpackage

// ===== design/frustum_plane_point_cull_core.sv =====
// Top level of the frustum plane point cull core: stores, sequencer, result register.
// Depends on fpc_pkg, fpc_mac and fpc_div.
//
//  channel | valid / ready       | payload
//  --------+---------------------+--------------------------------------------------
//  input   | i_valid / o_ready   | i_kind, i_matrix_index, i_element_value, i_point_*
//  output  | o_valid / i_ready   | o_inside_res, o_rejecting_plane, o_planes_valid,
//          |                     | o_degenerate_plane
//
// A point test runs six planes through one multiplier, stopping early when a plane
// rejects, and the length of a compute item is set by the bit-serial square root (31
// steps per plane) and divider (32 steps for each of up to 24 coefficients). o_ready is
// high only when the sequencer is idle; the result register holds one beat, and the next
// item stalls at its end until that beat drains. Reset is synchronous, active low, and
// clears all stores.
module frustum_plane_point_cull_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_matrix_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_inside_res,
    output logic [2:0]  o_rejecting_plane,
    output logic        o_planes_valid,
    output logic        o_degenerate_plane
);
    import fpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MUL_ACC, S_PLANE, S_SQ, S_SQ_ACC, S_SQRT, S_SQRT_W,
        S_DIV, S_DIV_W, S_TEST, S_TEST_ACC, S_OUT
    } t_state;

    t_state r_state;
    t_value r_proj [16];
    t_value r_view [16];
    t_value r_plane [24];
    t_acc   r_m [16];
    logic   r_ready_flag;
    logic   r_degen;
    logic   r_inside;
    logic [2:0] r_reject;
    logic [3:0] r_elem;
    logic [2:0] r_k;
    logic [2:0] r_p;
    logic [2:0] r_kk;
    logic signed [PROD_WIDTH-1:0] r_acc;
    logic signed [DIST_WIDTH-1:0] r_dist;
    logic [ACC_WIDTH-1:0] r_mag [4];
    logic [3:0]           r_neg;
    logic [LEN_WIDTH-1:0] r_len;
    logic signed [31:0]   r_px, r_py, r_pz;
    logic                 r_pend;

    t_value w_a, w_b;
    logic signed [PROD_WIDTH-1:0] w_prod;
    logic                 w_div_start, w_div_sqrt, w_div_done;
    logic [SUM_WIDTH-1:0] w_div_num;
    logic [QUO_WIDTH-1:0] w_quo;

    fpc_mac u_mac (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_prod));
    fpc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_sqrt(w_div_sqrt),
        .i_num(w_div_num), .i_den(r_len), .o_done(w_div_done), .o_quo(w_quo)
    );

    // Plane coefficients before normalisation, straight from the product matrix.
    t_acc  w_pc [4];
    logic [ACC_WIDTH-1:0] w_pm [4];
    logic [ACC_WIDTH-1:0] w_mx;
    logic [4:0]           w_sh;
    always_comb begin
        w_mx = '0;
        for (int k = 0; k < 4; k++) begin
            w_pc[k] = plane_add(r_p) ? r_m[k*4+3] + r_m[k*4+plane_col(r_p)]
                                     : r_m[k*4+3] - r_m[k*4+plane_col(r_p)];
            w_pm[k] = w_pc[k][ACC_WIDTH-1] ? ACC_WIDTH'(-w_pc[k]) : ACC_WIDTH'(w_pc[k]);
            if (k < 3 && w_pm[k] > w_mx) w_mx = w_pm[k];
        end
        // The largest shift that still leaves the normal at or above the limit is
        // one short of the shift needed.
        w_sh = '0;
        for (int s = 1; s <= ACC_WIDTH - NORM_BITS; s++) begin
            if ((w_mx >> (s - 1)) >= ACC_WIDTH'(1 << NORM_BITS)) w_sh = 5'(s);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_MUL: begin
                w_a = r_view[{r_elem[3:2], r_k[1:0]}];
                w_b = r_proj[{r_k[1:0], r_elem[1:0]}];
            end
            S_SQ: begin
                w_a = VALUE_WIDTH'(r_mag[r_kk[1:0]][NORM_BITS-1:0]);
                w_b = VALUE_WIDTH'(r_mag[r_kk[1:0]][NORM_BITS-1:0]);
            end
            S_TEST: begin
                w_a = r_plane[{r_p, r_kk[1:0]}];
                unique case (r_kk[1:0])
                    2'd0: w_b = r_px;
                    2'd1: w_b = r_py;
                    default: w_b = r_pz;
                endcase
            end
            default: ;
        endcase
    end

    // Any magnitude at or above the length times 2^15 saturates the coefficient, so
    // it is capped there to keep the quotient within the value width.
    logic [ACC_WIDTH-1:0] w_cap, w_mag_cap;
    assign w_cap     = ACC_WIDTH'(r_len) << (VALUE_WIDTH - 1 - FRACTION_BITS);
    assign w_mag_cap = (r_mag[r_kk[1:0]] < w_cap) ? r_mag[r_kk[1:0]] : w_cap;

    assign w_div_num  = (r_state == S_SQRT) ? SUM_WIDTH'(r_acc)
                                            : SUM_WIDTH'(w_mag_cap);
    assign w_div_start = (r_state == S_SQRT) || (r_state == S_DIV);
    assign w_div_sqrt  = (r_state == S_SQRT);

    // Saturated coefficient from the quotient.
    logic [VALUE_WIDTH-1:0] w_qsat;
    t_value                 w_coef;
    assign w_qsat = VALUE_WIDTH'(w_quo);
    always_comb begin
        if (r_neg[r_kk[1:0]]) w_coef = t_value'(-w_qsat);
        else if (w_qsat[VALUE_WIDTH-1]) w_coef = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        else w_coef = t_value'(w_qsat);
    end

    assign o_ready = (r_state == S_IDLE);

    logic signed [DIST_WIDTH-1:0] w_dnext;
    assign w_dnext = r_dist + DIST_WIDTH'(w_prod);

    logic w_out_fire;
    assign w_out_fire = (r_state == S_OUT) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ready_flag <= 1'b0;
            o_valid      <= 1'b0;
            r_pend       <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_proj[i] <= '0;
                r_view[i] <= '0;
            end
            for (int i = 0; i < 24; i++) r_plane[i] <= '0;
        end else begin
            if (w_out_fire) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_inside <= (t_kind'(i_kind) == KIND_TEST);
                    r_reject <= PLANE_NONE;
                    r_degen  <= 1'b0;
                    r_px <= i_point_x;
                    r_py <= i_point_y;
                    r_pz <= i_point_z;
                    r_elem <= '0;
                    r_k <= '0;
                    r_p <= '0;
                    r_kk <= '0;
                    r_acc <= '0;
                    r_dist <= '0;
                    unique case (t_kind'(i_kind))
                        KIND_LOAD_PROJ: begin
                            r_proj[i_matrix_index] <= i_element_value;
                            r_state <= S_OUT;
                        end
                        KIND_LOAD_VIEW: begin
                            r_view[i_matrix_index] <= i_element_value;
                            r_state <= S_OUT;
                        end
                        KIND_COMPUTE: r_state <= S_MUL;
                        KIND_TEST: r_state <= S_TEST;
                    endcase
                end
                S_MUL: begin
                    r_state <= S_MUL_ACC;
                end
                S_MUL_ACC: begin
                    if (r_k == 3'd3) begin
                        r_m[r_elem] <= ACC_WIDTH'(r_acc + PROD_WIDTH'(w_prod >>> FRACTION_BITS));
                        r_acc <= '0;
                        r_k <= '0;
                        r_elem <= r_elem + 1'b1;
                        r_state <= (r_elem == 4'd15) ? S_PLANE : S_MUL;
                    end else begin
                        r_acc <= r_acc + PROD_WIDTH'(w_prod >>> FRACTION_BITS);
                        r_k <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_PLANE: begin
                    for (int k = 0; k < 4; k++) begin
                        r_mag[k] <= w_pm[k] >> w_sh;
                        r_neg[k] <= w_pc[k][ACC_WIDTH-1];
                    end
                    r_acc <= '0;
                    r_kk <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    r_acc <= r_acc + w_prod;
                    if (r_kk == 3'd2) begin
                        r_kk <= '0;
                        if (r_acc + w_prod == '0) begin
                            r_degen <= 1'b1;
                            for (int k = 0; k < 4; k++) r_plane[{r_p, 2'(k)}] <= '0;
                            r_p <= r_p + 1'b1;
                            if (r_p == 3'(NUM_PLANES - 1)) begin
                                r_ready_flag <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_PLANE;
                            end
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end else begin
                        r_kk <= r_kk + 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: r_state <= S_SQRT_W;
                S_SQRT_W: if (w_div_done) begin
                    r_len <= LEN_WIDTH'(w_quo);
                    r_kk <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DIV_W;
                S_DIV_W: if (w_div_done) begin
                    r_plane[{r_p, r_kk[1:0]}] <= w_coef;
                    if (r_kk == 3'd3) begin
                        r_kk <= '0;
                        r_p <= r_p + 1'b1;
                        if (r_p == 3'(NUM_PLANES - 1)) begin
                            r_ready_flag <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PLANE;
                        end
                    end else begin
                        r_kk <= r_kk + 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_TEST: begin
                    // Each product is registered, so it lands in the cycle after its operands are issued.
                    if (r_kk == 3'd3) begin
                        r_dist <= w_dnext + DIST_WIDTH'(r_plane[{r_p, 2'd3}]);
                        r_state <= S_TEST_ACC;
                    end else begin
                        r_pend <= 1'b1;
                        r_kk <= r_kk + 1'b1;
                        if (r_pend) r_dist <= w_dnext;
                    end
                end
                S_TEST_ACC: begin
                    r_pend <= 1'b0;
                    r_kk <= '0;
                    r_dist <= '0;
                    if (r_dist <= -DIST_WIDTH'(1 << FRACTION_BITS)) begin
                        r_inside <= 1'b0;
                        r_reject <= r_p;
                        r_state <= S_OUT;
                    end else if (r_p == 3'(NUM_PLANES - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_p <= r_p + 1'b1;
                        r_state <= S_TEST;
                    end
                end
                S_OUT: if (w_out_fire) begin
                    o_inside_res <= r_inside;
                    o_rejecting_plane <= r_reject;
                    o_planes_valid <= r_ready_flag;
                    o_degenerate_plane <= r_degen;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/fpc_mac.sv =====
// Shared signed multiplier with registered product, used for the matrix product,
// the squared normal length and the point distance. Depends on fpc_pkg.
module fpc_mac (
    input  logic                                  i_clk,
    input  fpc_pkg::t_value                       i_a,
    input  fpc_pkg::t_value                       i_b,
    output logic signed [fpc_pkg::PROD_WIDTH-1:0] o_p
);
    import fpc_pkg::*;

    logic signed [2*VALUE_WIDTH-1:0] w_full;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        o_p <= PROD_WIDTH'(w_full);
    end
endmodule

// ===== design/fpc_div.sv =====
// Restoring divider and square root, one result bit per cycle.
// Used for the normal length and the coefficient scaling. Depends on fpc_pkg.
module fpc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_sqrt,
    input  logic [fpc_pkg::SUM_WIDTH-1:0]       i_num,
    input  logic [fpc_pkg::LEN_WIDTH-1:0]       i_den,
    output logic                                o_done,
    output logic [fpc_pkg::QUO_WIDTH-1:0]       o_quo
);
    import fpc_pkg::*;

    localparam int REM_W = SUM_WIDTH + 2;
    localparam int CNT_W = $clog2(QUO_WIDTH + 1);

    logic             r_busy, r_sqrt;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_WIDTH-1:0] r_num;
    logic [REM_W-1:0]     r_rem;
    logic [QUO_WIDTH-1:0] r_quo;
    logic [LEN_WIDTH-1:0] r_den;

    logic [REM_W-1:0]     w_rem_sh, w_trial;
    logic                 w_ok;
    logic [SUM_WIDTH+FRACTION_BITS-1:0] w_dvd;

    // The dividend is the input scaled by the fraction bits. The caller keeps the
    // quotient within QUO_WIDTH bits, so the bits above them start as the remainder.
    assign w_dvd = {i_num, {FRACTION_BITS{1'b0}}};

    always_comb begin
        if (r_sqrt) begin
            w_rem_sh  = {r_rem[REM_W-3:0], r_num[SUM_WIDTH-1 -: 2]};
            w_trial   = REM_W'({r_quo, 2'b01});
        end else begin
            w_rem_sh  = {r_rem[REM_W-2:0], r_num[SUM_WIDTH-1]};
            w_trial   = REM_W'(r_den);
        end
        w_ok = w_rem_sh >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_sqrt;
                r_quo  <= '0;
                r_den  <= i_den;
                if (i_sqrt) begin
                    r_rem <= '0;
                    r_num <= i_num;
                    r_cnt <= CNT_W'(SUM_WIDTH / 2);
                end else begin
                    r_rem <= REM_W'(w_dvd >> QUO_WIDTH);
                    r_num <= {w_dvd[QUO_WIDTH-1:0], {(SUM_WIDTH-QUO_WIDTH){1'b0}}};
                    r_cnt <= CNT_W'(QUO_WIDTH);
                end
            end else if (r_busy) begin
                r_rem <= w_ok ? w_rem_sh - w_trial : w_rem_sh;
                r_quo <= {r_quo[QUO_WIDTH-2:0], w_ok};
                r_num <= r_sqrt ? {r_num[SUM_WIDTH-3:0], 2'b00} : {r_num[SUM_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;
endmodule

// ===== tb/tb_frustum_plane_point_cull_core.sv =====
// Testbench for the frustum plane point cull core: loads matrices, computes planes and
// tests points, checking every result beat against a local bit-exact predictor.
// Depends on fpc_pkg and frustum_plane_point_cull_core.
`timescale 1ns / 100ps

module tb_frustum_plane_point_cull_core;
    import fpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic       passed;
        logic [2:0] reject;
        logic       ready;
        logic       degen;
    } t_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_kind = KIND_LOAD_PROJ;
    logic [3:0]         i_matrix_index = '0;
    logic signed [31:0] i_element_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_inside_res;
    logic [2:0]         o_rejecting_plane;
    logic               o_planes_valid;
    logic               o_degenerate_plane;

    frustum_plane_point_cull_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_matrix_index(i_matrix_index),
        .i_element_value(i_element_value), .i_point_x(i_point_x),
        .i_point_y(i_point_y), .i_point_z(i_point_z), .o_valid(o_valid),
        .i_ready(i_ready), .o_inside_res(o_inside_res),
        .o_rejecting_plane(o_rejecting_plane), .o_planes_valid(o_planes_valid),
        .o_degenerate_plane(o_degenerate_plane)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state.
    longint   proj_mat[16];
    longint   view_mat[16];
    longint   plane_coef[24];
    bit       planes_done;
    t_verdict verdict_q[$];

    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int tests_seen = 0;
    int rejects_seen = 0;
    int degen_seen = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    function automatic longint floor_shift(longint v);
        return v >>> FRACTION_BITS;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint scaled_coef(longint mag, bit neg, longint len);
        longint lim, q, r, m;
        lim = 64'sd1 <<< (VALUE_WIDTH - 1);
        q = mag / len;
        r = mag % len;
        if (q > (lim >>> FRACTION_BITS)) m = lim;
        else m = (q <<< FRACTION_BITS) + ((r <<< FRACTION_BITS) / len);
        if (m > lim) m = lim;
        if (!neg && m == lim) m = lim - 1;
        return neg ? -m : m;
    endfunction

    function automatic bit derive_planes();
        longint m[16];
        longint mag[4];
        bit     neg[4];
        longint mx, sum, len, t, v;
        bit     degen;
        int     s;
        degen = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                m[r*4+c] = 0;
                for (int k = 0; k < 4; k++)
                    m[r*4+c] += floor_shift(view_mat[r*4+k] * proj_mat[k*4+c]);
            end
        for (int p = 0; p < NUM_PLANES; p++) begin
            mx = 0;
            for (int k = 0; k < 4; k++) begin
                t = m[k*4 + plane_col(3'(p))];
                v = plane_add(3'(p)) ? m[k*4+3] + t : m[k*4+3] - t;
                neg[k] = v < 0;
                mag[k] = neg[k] ? -v : v;
                if (k < 3 && mag[k] > mx) mx = mag[k];
            end
            s = 0;
            while ((mx >>> s) >= (64'sd1 <<< NORM_BITS)) s++;
            sum = 0;
            for (int k = 0; k < 4; k++) mag[k] = mag[k] >>> s;
            for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
            if (sum == 0) begin
                degen = 1;
                for (int k = 0; k < 4; k++) plane_coef[p*4+k] = 0;
            end else begin
                len = int_sqrt(sum);
                for (int k = 0; k < 4; k++)
                    plane_coef[p*4+k] = scaled_coef(mag[k], neg[k], len);
            end
        end
        planes_done = 1;
        return degen;
    endfunction

    // The distance sum can exceed 64 bits, so it is carried in 100 bits.
    function automatic t_verdict predict_item(t_kind kind, logic [3:0] idx,
                                              longint val, longint x, longint y, longint z);
        t_verdict res;
        logic signed [99:0] dist_sum;
        res = '{passed: 1'b0, reject: PLANE_NONE, ready: 1'b0, degen: 1'b0};
        case (kind)
            KIND_LOAD_PROJ: proj_mat[idx] = val;
            KIND_LOAD_VIEW: view_mat[idx] = val;
            KIND_COMPUTE:   res.degen = derive_planes();
            default: begin
                res.passed = 1'b1;
                for (int p = 0; p < NUM_PLANES; p++) begin
                    dist_sum = 100'(plane_coef[p*4]) * 100'(x)
                             + 100'(plane_coef[p*4+1]) * 100'(y)
                             + 100'(plane_coef[p*4+2]) * 100'(z) + 100'(plane_coef[p*4+3]);
                    if (dist_sum <= -(100'sd1 <<< FRACTION_BITS)) begin
                        res.passed = 1'b0;
                        res.reject = 3'(p);
                        break;
                    end
                end
            end
        endcase
        res.ready = planes_done;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, beats_out, got, want);
        errors++;
    endtask

    // Sends one item, sometimes idling between bursts; the predictor runs on acceptance.
    task automatic send_item(t_kind kind, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_matrix_index <= idx;
        i_element_value <= val;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do @(posedge i_clk); while (!o_ready);
        verdict_q.push_back(predict_item(kind, idx, longint'($signed(val)),
            longint'($signed(x)), longint'($signed(y)), longint'($signed(z))));
        beats_in++;
        if (kind == KIND_TEST) tests_seen++;
    endtask

    // Receiver stall pattern and result checking.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                beats_out++;
                if (verdict_q.size() == 0) begin
                    $display("result beat %0d arrived with nothing expected", beats_out);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_inside_res !== want.passed)
                        report_mismatch("inside", o_inside_res, want.passed);
                    if (o_rejecting_plane !== want.reject)
                        report_mismatch("rejecting plane", o_rejecting_plane, want.reject);
                    if (o_planes_valid !== want.ready)
                        report_mismatch("planes valid", o_planes_valid, want.ready);
                    if (o_degenerate_plane !== want.degen)
                        report_mismatch("degenerate", o_degenerate_plane, want.degen);
                    if (!want.passed && want.reject != PLANE_NONE) rejects_seen++;
                    if (want.degen) degen_seen++;
                end
            end
            case (beats_out % 64) inside
                [0:15]:  i_ready <= 1'b1;
                default: i_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_element();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8192)) - 4096) <<< 8;
            2: return 32'sd0;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'sd0;
            default: return 32'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    task automatic load_matrices(bit identity_like);
        for (int i = 0; i < 16; i++) begin
            send_item(KIND_LOAD_PROJ, 4'(i),
                      identity_like ? ((i % 5 == 0) ? 32'sh10000 : 32'sd0) : rand_element(),
                      $urandom(), $urandom(), $urandom());
            send_item(KIND_LOAD_VIEW, 4'(i),
                      identity_like ? ((i % 5 == 0) ? 32'sh10000 : 32'sd0) : rand_element(),
                      $urandom(), $urandom(), $urandom());
        end
    endtask

    // Points before any compute, compute on zero matrices, and field extremes.
    task automatic test_directed();
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'h8000_0000, 32'h7fff_ffff, 32'sd5);
        send_item(KIND_COMPUTE, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_item(KIND_TEST, 4'd15, 32'hffff_ffff, 32'sd1, 32'sd1, 32'sd1);
        send_item(KIND_LOAD_PROJ, 4'd15, 32'h7fff_ffff, 32'sd0, 32'sd0, 32'sd0);
        send_item(KIND_LOAD_VIEW, 4'd0, 32'h8000_0000, 32'sd0, 32'sd0, 32'sd0);
        send_item(KIND_COMPUTE, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        load_matrices(1'b1);
        send_item(KIND_COMPUTE, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        // Unit cube: each face in turn, plus the centre and the exact boundary.
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd2, 32'sd0, 32'sd0);
        send_item(KIND_TEST, 4'd0, 32'sd0, -32'sd2, 32'sd0, 32'sd0);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd0, -32'sd2, 32'sd0);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd2, 32'sd0);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd2);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd2);
        send_item(KIND_TEST, 4'd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1);
    endtask

    // Random matrix sets or partial element updates, each followed by a compute and a run of point tests.
    task automatic test_random_scenes();
        int budget;
        budget = 1400;
        while (budget > 0) begin
            if ($urandom_range(0, 3) == 0) load_matrices(1'($urandom_range(0, 1)));
            else begin
                for (int i = 0; i < $urandom_range(1, 6); i++)
                    send_item(t_kind'($urandom_range(0, 1)), 4'($urandom()), rand_element(),
                              $urandom(), $urandom(), $urandom());
            end
            send_item(KIND_COMPUTE, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                      $urandom());
            for (int i = 0; i < 30; i++)
                send_item(KIND_TEST, 4'($urandom()), $urandom(), rand_coord(), rand_coord(),
                          rand_coord());
            budget -= 40;
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            proj_mat[i] = 0;
            view_mat[i] = 0;
        end
        for (int i = 0; i < 24; i++) plane_coef[i] = 0;
        planes_done = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_scenes();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d items, %0d point tests, %0d rejections, %0d degenerate computes",
                 beats_in, tests_seen, rejects_seen, degen_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule
